// File: rtl/core/los_pkg.sv
// shared types, constants and helpers for the line-of-sight angle tracker
`default_nettype none
package los_pkg;

    localparam int unsigned TIME_W   = 48;
    localparam int unsigned POS_W    = 24;
    localparam int unsigned QUAT_W   = 16;
    localparam int unsigned D_W      = POS_W + 1;
    localparam int unsigned QP_W     = 2 * QUAT_W;
    localparam int unsigned M_W      = QP_W + 2;
    localparam int unsigned P_W      = M_W + D_W;
    localparam int unsigned B_W      = P_W + 2;
    localparam int unsigned NM_W     = 29;
    localparam int unsigned SQ_W     = 60;
    localparam int unsigned ROOT_W   = SQ_W / 2;
    localparam int unsigned SQ_ITER  = SQ_W / 2;
    localparam int unsigned CW       = 34;
    localparam int unsigned ZW       = 34;
    localparam int unsigned RATE_W   = 10;
    localparam int unsigned ANG_W    = 15;
    localparam int unsigned RNG_W    = 24;
    localparam int unsigned RNG2_W   = 2 * RNG_W;
    localparam int unsigned R2_W     = 2 * D_W;
    localparam int unsigned PROD_W   = TIME_W + RATE_W;
    localparam int unsigned AZ_W     = 16;
    localparam int unsigned EL_W     = 15;
    localparam int unsigned Q13_W    = 17;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ATAN_LEN = 24;

    localparam logic [1:0] REG_RATE  = 2'd0;
    localparam logic [1:0] REG_ANGLE = 2'd1;
    localparam logic [1:0] REG_RANGE = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RST  = 10'd30;
    localparam logic [ANG_W-1:0]  ANGLE_RST = 15'd5734;
    localparam logic [RNG_W-1:0]  RANGE_RST = 24'd51200;

    localparam logic [PROD_W-1:0] US_PER_S = 58'd1000000;

    localparam logic signed [ZW-1:0]    PI_Q30 = 34'sd3373259426;
    localparam logic signed [Q13_W-1:0] AZ_MAX = 17'sd25736;
    localparam logic signed [Q13_W-1:0] EL_MAX = 17'sd12868;

    localparam logic signed [ZW-1:0] ATAN_Q30 [ATAN_LEN] = '{
        34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
        34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
        34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
        34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
        34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
        34'sd1024,      34'sd512,       34'sd256,       34'sd128
    };

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIME,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_SUM,
        S_MAG,
        S_NORM,
        S_SQ,
        S_ROOT,
        S_EL,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                  valid;
        logic                  is_el;
        logic                  zero;
        logic signed [CW-1:0]  x;
        logic signed [CW-1:0]  y;
        logic signed [ZW-1:0]  z;
    } t_cordic;

    // round half up from 2^-30 rad to q3.13 and clamp
    function automatic logic signed [Q13_W-1:0] to_q13(
        input logic signed [ZW-1:0]    z,
        input logic signed [Q13_W-1:0] lim
    );
        logic signed [ZW:0]    ze;
        logic signed [ZW:0]    half;
        logic signed [ZW:0]    sum;
        logic signed [ZW-17:0] a;
        logic signed [Q13_W-1:0] res;
        ze   = {z[ZW-1], z};
        half = (ZW+1)'(65536);
        sum  = ze + half;
        a    = sum[ZW:17];
        if (a > lim) begin
            res = lim;
        end else if (a < -lim) begin
            res = -lim;
        end else begin
            res = a[Q13_W-1:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/los_ifs.sv
// valid/ready channel interfaces for input items and results
`default_nettype none
interface los_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [los_pkg::TIME_W-1:0]           sim_time_us;
    logic signed [los_pkg::POS_W-1:0]     target_x;
    logic signed [los_pkg::POS_W-1:0]     target_y;
    logic signed [los_pkg::POS_W-1:0]     target_z;
    logic signed [los_pkg::POS_W-1:0]     vehicle_x;
    logic signed [los_pkg::POS_W-1:0]     vehicle_y;
    logic signed [los_pkg::POS_W-1:0]     vehicle_z;
    logic signed [los_pkg::QUAT_W-1:0]    quat_w;
    logic signed [los_pkg::QUAT_W-1:0]    quat_x;
    logic signed [los_pkg::QUAT_W-1:0]    quat_y;
    logic signed [los_pkg::QUAT_W-1:0]    quat_z;

    modport source (
        output valid, sim_time_us, target_x, target_y, target_z,
               vehicle_x, vehicle_y, vehicle_z, quat_w, quat_x, quat_y, quat_z,
        input  ready
    );
    modport sink (
        input  valid, sim_time_us, target_x, target_y, target_z,
               vehicle_x, vehicle_y, vehicle_z, quat_w, quat_x, quat_y, quat_z,
        output ready
    );
endinterface

interface los_out_if;
    logic                               valid;
    logic                               ready;
    logic [los_pkg::TIME_W-1:0]         stamp_us;
    logic signed [los_pkg::AZ_W-1:0]    azimuth;
    logic signed [los_pkg::EL_W-1:0]    elevation;
    logic                               tracking;

    modport source (
        output valid, stamp_us, azimuth, elevation, tracking,
        input  ready
    );
    modport sink (
        input  valid, stamp_us, azimuth, elevation, tracking,
        output ready
    );
endinterface
`default_nettype wire

// File: rtl/core/los_cordic_cell.sv
// one vectoring cordic micro-rotation with a fixed shift
`default_nettype none
module los_cordic_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  los_pkg::t_cordic i_cell,
    output los_pkg::t_cordic o_cell
);
    import los_pkg::*;

    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] z;
    t_cordic              n_cell;
    t_cordic              r_cell;

    always_comb begin
        x      = i_cell.x;
        y      = i_cell.y;
        z      = i_cell.z;
        xs     = x >>> SHIFT;
        ys     = y >>> SHIFT;
        n_cell = i_cell;
        if (y > 0) begin
            n_cell.x = x + ys;
            n_cell.y = y - xs;
            n_cell.z = z + ATAN_Q30[SHIFT];
        end else begin
            n_cell.x = x - ys;
            n_cell.y = y + xs;
            n_cell.z = z - ATAN_Q30[SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else begin
            r_cell.valid <= n_cell.valid;
        end
        r_cell.is_el <= n_cell.is_el;
        r_cell.zero  <= n_cell.zero;
        r_cell.x     <= n_cell.x;
        r_cell.y     <= n_cell.y;
        r_cell.z     <= n_cell.z;
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

// File: rtl/core/los_isqrt.sv
// bit-serial floor integer square root, one result bit per cycle
`default_nettype none
module los_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [los_pkg::SQ_W-1:0]     i_n,
    output logic                         o_done,
    output logic [los_pkg::ROOT_W-1:0]   o_root
);
    import los_pkg::*;

    localparam int unsigned CNT_W = $clog2(SQ_ITER);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SQ_W-1:0]  r_n;
    logic [SQ_W-1:0]  r_r;
    logic [SQ_W-1:0]  r_bit;
    logic [SQ_W-1:0]  trial;
    logic             fits;

    assign trial = r_r + r_bit;
    assign fits  = r_n >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQ_ITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_r   <= '0;
            r_bit <= {2'b01, (SQ_W-2)'(0)};
        end else if (r_busy) begin
            if (fits) begin
                r_n <= r_n - trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[ROOT_W-1:0];

endmodule
`default_nettype wire

// File: rtl/core/line_of_sight_angle_tracker.sv
// line-of-sight azimuth/elevation tracker top level
// one item at a time; an item that publishes steps through the time check, the multiply,
// sum, magnitude and normalize states, the square root and the cordic cell chain, and waits
// in the output state while a result stalls
// an item that does not publish frees the input again after the time and check states
// synchronous active-low reset clears control state and loads register defaults
`default_nettype none
module line_of_sight_angle_tracker #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [los_pkg::ADDR_W-1:0]     paddr,
    input  logic [los_pkg::DATA_W-1:0]     pwdata,
    output logic [los_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    los_in_if.sink                         i_in,
    los_out_if.source                      o_out
);
    import los_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [RATE_W-1:0] r_rate;
    logic [ANG_W-1:0]  r_angle;
    logic [RNG_W-1:0]  r_range;

    logic [TIME_W-1:0]         r_t;
    logic [TIME_W-1:0]         r_last;
    logic [TIME_W-1:0]         elapsed;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_late;
    logic                      pass;
    logic signed [D_W-1:0]     r_d [3];
    logic signed [QUAT_W-1:0]  r_qw, r_qx, r_qy, r_qz;
    logic signed [QP_W-1:0]    r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic [R2_W-1:0]           r_dd [3];
    logic signed [M_W-1:0]     r_m [3][3];
    logic [R2_W-1:0]           r_r2;
    logic [RNG2_W-1:0]         r_lim2;
    logic signed [P_W-1:0]     r_p [3][3];
    logic signed [B_W-1:0]     r_b [3];
    logic                      r_sgn [3];
    logic [B_W-1:0]            r_mag [3];
    logic                      big;
    logic                      mid;
    logic [ROOT_W-1:0]         r_hy;
    logic signed [Q13_W-1:0]   r_az;
    logic signed [Q13_W-1:0]   r_el;

    logic                      r_ov;
    logic [TIME_W-1:0]         r_ostamp;
    logic signed [AZ_W-1:0]    r_oaz;
    logic signed [EL_W-1:0]    r_oel;
    logic                      r_otrk;

    logic in_ready;
    logic push_az;
    logic push_el;
    logic sq_start;
    logic out_load;

    logic signed [CW-1:0]      bv [3];
    logic signed [CW-1:0]      cx;
    logic signed [CW-1:0]      cy;
    logic                      cneg;
    t_cordic                   head;
    t_cordic                   chain [0:CORDIC_STEPS];
    t_cordic                   tail;
    logic signed [Q13_W-1:0]   q13;

    logic [2*NM_W-1:0]         sqx;
    logic [2*NM_W-1:0]         sqy;
    logic [SQ_W-1:0]           sq_in;
    logic                      sq_done;
    logic [ROOT_W-1:0]         sq_root;

    logic [Q13_W-1:0]          az_abs;
    logic [Q13_W-1:0]          el_abs;
    logic                      trk;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= RATE_RST;
            r_angle <= ANGLE_RST;
            r_range <= RANGE_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[ADDR_W-1:2])
                REG_RATE:  r_rate  <= pwdata[RATE_W-1:0];
                REG_ANGLE: r_angle <= pwdata[ANG_W-1:0];
                REG_RANGE: r_range <= pwdata[RNG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_RATE:  prdata = DATA_W'(r_rate);
            REG_ANGLE: prdata = DATA_W'(r_angle);
            REG_RANGE: prdata = DATA_W'(r_range);
            default:   prdata = '0;
        endcase
    end

    // sequencer
    assign elapsed = r_t - r_last;
    assign pass    = !r_late && (r_prod > US_PER_S);
    assign big     = (|r_mag[0][B_W-1:NM_W+4]) | (|r_mag[1][B_W-1:NM_W+4])
                   | (|r_mag[2][B_W-1:NM_W+4]);
    assign mid     = (|r_mag[0][B_W-1:NM_W]) | (|r_mag[1][B_W-1:NM_W])
                   | (|r_mag[2][B_W-1:NM_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_TIME;
            S_TIME:  n_state = S_CHECK;
            S_CHECK: n_state = pass ? S_MUL1 : S_IDLE;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_SUM;
            S_SUM:   n_state = S_MAG;
            S_MAG:   n_state = S_NORM;
            S_NORM:  if (!mid) n_state = S_SQ;
            S_SQ:    n_state = S_ROOT;
            S_ROOT:  if (sq_done) n_state = S_EL;
            S_EL:    n_state = S_DRAIN;
            S_DRAIN: if (tail.valid && tail.is_el) n_state = S_OUT;
            S_OUT:   if (!r_ov || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        push_az  = 1'b0;
        push_el  = 1'b0;
        sq_start = 1'b0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: in_ready = 1'b1;
            S_SQ: begin
                push_az  = 1'b1;
                sq_start = 1'b1;
            end
            S_EL:  push_el  = 1'b1;
            S_OUT: out_load = !r_ov || o_out.ready;
            default: ;
        endcase
    end

    assign i_in.ready = in_ready;

    // last publication time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (r_state == S_CHECK && pass) begin
            r_last <= r_t;
        end
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    r_t    <= i_in.sim_time_us;
                    r_d[0] <= D_W'(i_in.target_x) - D_W'(i_in.vehicle_x);
                    r_d[1] <= D_W'(i_in.target_y) - D_W'(i_in.vehicle_y);
                    r_d[2] <= D_W'(i_in.target_z) - D_W'(i_in.vehicle_z);
                    r_qw   <= i_in.quat_w;
                    r_qx   <= i_in.quat_x;
                    r_qy   <= i_in.quat_y;
                    r_qz   <= i_in.quat_z;
                end
            end
            S_TIME: begin
                r_prod <= elapsed * r_rate;
                r_late <= r_t < r_last;
            end
            S_MUL1: begin
                r_ww <= r_qw * r_qw;
                r_xx <= r_qx * r_qx;
                r_yy <= r_qy * r_qy;
                r_zz <= r_qz * r_qz;
                r_xy <= r_qx * r_qy;
                r_wz <= r_qw * r_qz;
                r_xz <= r_qx * r_qz;
                r_wy <= r_qw * r_qy;
                r_yz <= r_qy * r_qz;
                r_wx <= r_qw * r_qx;
                for (int i = 0; i < 3; i++) begin
                    r_dd[i] <= r_d[i] * r_d[i];
                end
            end
            S_MUL2: begin
                r_m[0][0] <= r_ww + r_xx - r_yy - r_zz;
                r_m[0][1] <= (r_xy + r_wz) <<< 1;
                r_m[0][2] <= (r_xz - r_wy) <<< 1;
                r_m[1][0] <= (r_xy - r_wz) <<< 1;
                r_m[1][1] <= r_ww - r_xx + r_yy - r_zz;
                r_m[1][2] <= (r_yz + r_wx) <<< 1;
                r_m[2][0] <= (r_xz + r_wy) <<< 1;
                r_m[2][1] <= (r_yz - r_wx) <<< 1;
                r_m[2][2] <= r_ww - r_xx - r_yy + r_zz;
                r_r2      <= r_dd[0] + r_dd[1] + r_dd[2];
                r_lim2    <= r_range * r_range;
            end
            S_MUL3: begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        r_p[i][j] <= r_m[i][j] * r_d[j];
                    end
                end
            end
            S_SUM: begin
                for (int i = 0; i < 3; i++) begin
                    r_b[i] <= r_p[i][0] + r_p[i][1] + r_p[i][2];
                end
            end
            S_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    r_sgn[i] <= r_b[i][B_W-1];
                    r_mag[i] <= r_b[i][B_W-1] ? -r_b[i] : r_b[i];
                end
            end
            S_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    if (big) begin
                        r_mag[i] <= r_mag[i] >> 4;
                    end else if (mid) begin
                        r_mag[i] <= r_mag[i] >> 1;
                    end
                end
            end
            S_ROOT: begin
                if (sq_done) begin
                    r_hy <= sq_root;
                end
            end
            default: ;
        endcase
    end

    // square root of the horizontal length
    assign sqx   = r_mag[0][NM_W-1:0] * r_mag[0][NM_W-1:0];
    assign sqy   = r_mag[1][NM_W-1:0] * r_mag[1][NM_W-1:0];
    assign sq_in = SQ_W'(sqx) + SQ_W'(sqy);

    los_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_n     (sq_in),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // cordic chain entry with half-plane fold
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            bv[i] = r_sgn[i] ? -$signed(CW'(r_mag[i][NM_W-1:0]))
                             :  $signed(CW'(r_mag[i][NM_W-1:0]));
        end
        cx   = push_el ? $signed(CW'(r_hy)) : bv[0];
        cy   = push_el ? -bv[2] : bv[1];
        cneg = cx < 0;
        head.valid = push_az || push_el;
        head.is_el = push_el;
        head.zero  = (cx == 0) && (cy == 0);
        head.x     = cneg ? -cx : cx;
        head.y     = cneg ? -cy : cy;
        if (cneg) begin
            head.z = (cy >= 0) ? PI_Q30 : -PI_Q30;
        end else begin
            head.z = '0;
        end
    end

    assign chain[0] = head;

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cell
        los_cordic_cell #(
            .SHIFT (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cell  (chain[gi]),
            .o_cell  (chain[gi+1])
        );
    end

    assign tail = chain[CORDIC_STEPS];
    assign q13  = tail.zero ? '0 : to_q13(tail.z, tail.is_el ? EL_MAX : AZ_MAX);

    always_ff @(posedge i_clk) begin
        if (tail.valid && !tail.is_el) begin
            r_az <= q13;
        end
        if (tail.valid && tail.is_el) begin
            r_el <= q13;
        end
    end

    // tracking decision and result register
    assign az_abs = r_az[Q13_W-1] ? -r_az : r_az;
    assign el_abs = r_el[Q13_W-1] ? -r_el : r_el;
    assign trk    = (az_abs < Q13_W'(r_angle)) && (el_abs < Q13_W'(r_angle))
                 && (r_r2 < R2_W'(r_lim2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ostamp <= r_t;
            r_oaz    <= r_az[AZ_W-1:0];
            r_oel    <= r_el[EL_W-1:0];
            r_otrk   <= trk;
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.stamp_us  = r_ostamp;
    assign o_out.azimuth   = r_oaz;
    assign o_out.elevation = r_oel;
    assign o_out.tracking  = r_otrk;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while a transaction is in progress");

    a_root_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> (r_state == S_ROOT))
        else $error("square root finished outside its wait state");

    a_el_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tail.valid && tail.is_el) |-> (r_state == S_DRAIN))
        else $error("elevation left the cell chain unexpectedly");

    a_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> (o_out.stamp_us == r_last))
        else $error("result stamp differs from last publication time");
`endif

endmodule
`default_nettype wire

// File: test/los_angle_checker.sv
// checker for the line-of-sight angle tracker: predicts and compares results
`timescale 1ns / 100ps
module los_angle_checker #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [los_pkg::ADDR_W-1:0]    paddr,
    input  logic [los_pkg::DATA_W-1:0]    pwdata,
    los_in_if                             in_mon,
    los_out_if                            out_mon,
    output int                            o_fail_count,
    output int                            o_pending
);
    import los_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0]       stamp;
        logic signed [AZ_W-1:0]  az;
        logic signed [EL_W-1:0]  el;
        logic                    trk;
    } t_los;

    t_los               los_q[$];
    logic [RATE_W-1:0]  rate_hz;
    logic [ANG_W-1:0]   ang_lim;
    logic [RNG_W-1:0]   rng_lim;
    logic [TIME_W-1:0]  last_pub;
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = los_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring cordic, angle in 2^-30 rad
    function automatic longint vec_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += longint'(ATAN_Q30[i]);
            end else begin
                x -= ys; y += xs; z -= longint'(ATAN_Q30[i]);
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(longint z, longint lim);
        longint a;
        a = (z + 65536) >>> 17;
        if (a > lim) a = lim;
        if (a < -lim) a = -lim;
        return a;
    endfunction

    function automatic longint shrink(longint v, int s);
        longint m;
        m = ((v < 0) ? -v : v) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic t_los predict_los();
        t_los   r;
        longint dx, dy, dz, w, x, y, z, bx, by, bz, m, hy, az, el;
        longint unsigned r2, lim2;
        int     s;
        dx = longint'(in_mon.target_x) - longint'(in_mon.vehicle_x);
        dy = longint'(in_mon.target_y) - longint'(in_mon.vehicle_y);
        dz = longint'(in_mon.target_z) - longint'(in_mon.vehicle_z);
        w  = in_mon.quat_w; x = in_mon.quat_x; y = in_mon.quat_y; z = in_mon.quat_z;
        bx = (w*w + x*x - y*y - z*z)*dx + 2*(x*y + w*z)*dy + 2*(x*z - w*y)*dz;
        by = 2*(x*y - w*z)*dx + (w*w - x*x + y*y - z*z)*dy + 2*(y*z + w*x)*dz;
        bz = 2*(x*z + w*y)*dx + 2*(y*z - w*x)*dy + (w*w - x*x - y*y + z*z)*dz;
        m = abs_of(bx);
        if (abs_of(by) > m) m = abs_of(by);
        if (abs_of(bz) > m) m = abs_of(bz);
        s = 0;
        while ((m >>> s) >= (64'd1 << 29)) s++;
        bx = shrink(bx, s);
        by = shrink(by, s);
        bz = shrink(bz, s);
        hy = longint'(int_sqrt(longint'(bx*bx + by*by)));
        az = round_q13(vec_angle(by, bx), 25736);
        el = round_q13(vec_angle(-bz, hy), 12868);
        r2   = dx*dx + dy*dy + dz*dz;
        lim2 = longint'(rng_lim) * longint'(rng_lim);
        r.stamp = in_mon.sim_time_us;
        r.az    = az[AZ_W-1:0];
        r.el    = el[EL_W-1:0];
        r.trk   = abs_of(az) < ang_lim && abs_of(el) < ang_lim && r2 < lim2;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_los exp_r;
        t_los got;
        if (!i_rst_n) begin
            rate_hz  <= RATE_RST;
            ang_lim  <= ANGLE_RST;
            rng_lim  <= RANGE_RST;
            last_pub <= '0;
            los_q.delete();
            fails    <= 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_RATE:  rate_hz <= pwdata[RATE_W-1:0];
                    REG_ANGLE: ang_lim <= pwdata[ANG_W-1:0];
                    REG_RANGE: rng_lim <= pwdata[RNG_W-1:0];
                    default: ;
                endcase
            end
            if (in_mon.valid && in_mon.ready && in_mon.sim_time_us >= last_pub
                    && (64'(in_mon.sim_time_us - last_pub) * 64'(rate_hz)) > 64'd1000000)
            begin
                los_q.push_back(predict_los());
                last_pub <= in_mon.sim_time_us;
            end
            if (out_mon.valid && out_mon.ready) begin
                got = {out_mon.stamp_us, out_mon.azimuth, out_mon.elevation, out_mon.tracking};
                if (los_q.size() == 0) begin
                    if (fails < 10) $display("unexpected transaction: %p", got);
                    fails <= fails + 1;
                end else begin
                    exp_r = los_q.pop_front();
                    if (got !== exp_r) begin
                        if (fails < 10) $display("mismatch: expected %p actual %p", exp_r, got);
                        fails <= fails + 1;
                    end
                end
            end
        end
    end
endmodule

// File: test/tb_line_of_sight_angle_tracker.sv
// testbench top for the line-of-sight angle tracker: stimulus and verdict
`timescale 1ns / 100ps
module tb_line_of_sight_angle_tracker;
    import los_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel, penable, pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                calm;
    int                  fail_count, pending, cycles;
    longint unsigned     now_us;
    int                  rate_cur;

    los_in_if  in_if ();
    los_out_if out_if ();

    line_of_sight_angle_tracker u_dut (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .psel (psel), .penable (penable), .pwrite (pwrite), .paddr (paddr),
        .pwdata (pwdata), .prdata (prdata), .pready (pready),
        .i_in (in_if), .o_out (out_if)
    );

    los_angle_checker u_checker (
        .i_clk (i_clk), .i_rst_n (i_rst_n),
        .psel (psel), .penable (penable), .pwrite (pwrite), .pready (pready),
        .paddr (paddr), .pwdata (pwdata),
        .in_mon (in_if), .out_mon (out_if),
        .o_fail_count (fail_count), .o_pending (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        out_if.ready <= calm || ($urandom_range(0, 99) >= 31);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_line_of_sight_angle_tracker failed");
            $finish;
        end
    end

    task automatic send_sample(longint unsigned t, int tx, int ty, int tz, int vx, int vy,
                               int vz, int qw, int qx, int qy, int qz);
        logic taken;
        while (!calm && $urandom_range(0, 99) < 31) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.sim_time_us <= t[TIME_W-1:0];
        in_if.target_x    <= tx[POS_W-1:0];
        in_if.target_y    <= ty[POS_W-1:0];
        in_if.target_z    <= tz[POS_W-1:0];
        in_if.vehicle_x   <= vx[POS_W-1:0];
        in_if.vehicle_y   <= vy[POS_W-1:0];
        in_if.vehicle_z   <= vz[POS_W-1:0];
        in_if.quat_w      <= qw[QUAT_W-1:0];
        in_if.quat_x      <= qx[QUAT_W-1:0];
        in_if.quat_y      <= qy[QUAT_W-1:0];
        in_if.quat_z      <= qz[QUAT_W-1:0];
        // ready is sampled mid-cycle, ahead of the edge that takes the transaction
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = in_if.ready;
            @(posedge i_clk);
        end
    endtask

    task automatic reg_write(logic [1:0] idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_config(int unsigned r, int unsigned a, int unsigned g);
        drain();
        reg_write(REG_RATE, r);
        reg_write(REG_ANGLE, a);
        reg_write(REG_RANGE, g);
        rate_cur = r;
    endtask

    function automatic int s_rand(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // next time stamp, mostly just past the publish spacing
    function automatic longint unsigned next_time();
        int unsigned base, p;
        base = (rate_cur == 0) ? 50000 : 1000000 / rate_cur;
        p = $urandom_range(0, 99);
        if (p < 60) now_us += base + $urandom_range(0, 3);
        else if (p < 80) now_us += $urandom_range(0, base);
        else if (p < 90) now_us += $urandom_range(0, 32'h7fffffff);
        else if (now_us > base) now_us -= $urandom_range(0, base);
        return now_us;
    endfunction

    task automatic random_sample();
        int vx, vy, vz, dx, dy, dz;
        longint unsigned t;
        t = next_time();
        if ($urandom_range(0, 99) < 60) begin
            vx = s_rand(-4000000, 4000000);
            vy = s_rand(-4000000, 4000000);
            vz = s_rand(-4000000, 4000000);
            dx = s_rand(100, 60000);
            if ($urandom_range(0, 3) == 0) dx = -dx;
            dy = s_rand(-30000, 30000);
            dz = s_rand(-30000, 30000);
            send_sample(t, vx + dx, vy + dy, vz + dz, vx, vy, vz,
                        16384 - s_rand(0, 300), s_rand(-400, 400), s_rand(-400, 400),
                        s_rand(-400, 400));
        end else begin
            send_sample(t, s_rand(-8388608, 8388607), s_rand(-8388608, 8388607),
                        s_rand(-8388608, 8388607), s_rand(-8388608, 8388607),
                        s_rand(-8388608, 8388607), s_rand(-8388608, 8388607),
                        s_rand(-16384, 16384), s_rand(-16384, 16384),
                        s_rand(-16384, 16384), s_rand(-16384, 16384));
        end
    endtask

    initial begin
        i_clk = 1'b0; i_rst_n = 1'b0; cycles = 0; calm = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_if.valid = 1'b0; in_if.sim_time_us = '0;
        in_if.target_x = '0; in_if.target_y = '0; in_if.target_z = '0;
        in_if.vehicle_x = '0; in_if.vehicle_y = '0; in_if.vehicle_z = '0;
        in_if.quat_w = '0; in_if.quat_x = '0; in_if.quat_y = '0; in_if.quat_z = '0;
        out_if.ready = 1'b0;
        rate_cur = 30; now_us = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset configuration
        send_sample(0, 1000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(40000, 1000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(80000, 8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                    16384, 0, 0, 0);
        send_sample(120000, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                    -16384, 16384, -16384, 16384);
        send_sample(160000, 5, 5, 5, 5, 5, 5, 16384, 0, 0, 0);
        send_sample(200000, 3000, 400, -200, 0, 0, 0, 0, 0, 0, 0);
        send_sample(100000, 3000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(233333, 3000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(233334, 3000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(280000, -3000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(320000, -3000, -1, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(360000, 0, 0, 5000, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(400000, 0, 0, -5000, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(440000, 0, 5000, 0, 0, 0, 0, 11585, 0, 0, 11585);
        send_sample(480000, 3000, 100, 50, 0, 0, 0, 300, 20, -70, 5);
        send_sample(520000, 51199, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(560000, 51200, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        send_sample(600000, 4000, 2800, 0, 0, 0, 0, 16384, 0, 0, 0);
        now_us = 600000;

        repeat (200) random_sample();
        set_config(1000, 25736, 16777215);
        calm = 1'b1;
        repeat (150) random_sample();
        calm = 1'b0;
        repeat (150) random_sample();
        set_config(1, 0, 0);
        repeat (40) random_sample();
        set_config(0, 5734, 51200);
        repeat (30) random_sample();
        set_config($urandom_range(1, 1000), $urandom_range(0, 25736),
                   $urandom_range(0, 16777215));
        repeat (300) random_sample();
        set_config(100, 5734, 51200);
        now_us = 64'h7fff_0000_0000 | 64'($urandom());
        repeat (300) random_sample();
        send_sample(64'hffff_ffff_ffff, 1000, 0, 0, 0, 0, 0, 16384, 0, 0, 0);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("tb_line_of_sight_angle_tracker passed");
        end else begin
            $display("tb_line_of_sight_angle_tracker failed");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/core/los_pkg.sv
rtl/core/los_ifs.sv
rtl/core/los_cordic_cell.sv
rtl/core/los_isqrt.sv
rtl/core/line_of_sight_angle_tracker.sv
test/los_angle_checker.sv
test/tb_line_of_sight_angle_tracker.sv
